// ===== sv/pkcs1_pkg.sv =====
// ----------------------------------------------------------------------------
// pkcs1_pkg
// Types, constants and the DigestInfo prefix table for the PKCS#1 v1.5
// signature encoding check.
// ----------------------------------------------------------------------------
package pkcs1_pkg;

    localparam int MAX_MODULUS_BYTES = 512;
    localparam int MAX_DIGEST_BYTES  = 64;
    localparam int PREFIX_BYTES      = 19;
    localparam int MIN_PAD_BYTES     = 8;
    localparam int HEADER_BYTES      = 3 + PREFIX_BYTES + MIN_PAD_BYTES;

    localparam int MLEN_W  = 10;
    localparam int DLEN_W  = 7;
    localparam int POS_W   = 10;
    localparam int DADDR_W = $clog2(MAX_DIGEST_BYTES);
    localparam int PIDX_W  = $clog2(PREFIX_BYTES);
    localparam int CFG_W   = MLEN_W;
    localparam int CIDX_W  = 2;

    localparam logic [CIDX_W-1:0] REG_MODULUS_LEN   = 2'd0;
    localparam logic [CIDX_W-1:0] REG_DIGEST_LEN    = 2'd1;
    localparam logic [CIDX_W-1:0] REG_SIGNATURE_LEN = 2'd2;

    localparam logic [MLEN_W-1:0] MODULUS_LEN_RST   = 10'd256;
    localparam logic [DLEN_W-1:0] DIGEST_LEN_RST    = 7'd32;
    localparam logic [MLEN_W-1:0] SIGNATURE_LEN_RST = 10'd256;

    typedef enum logic [2:0] {
        STATUS_MATCH            = 3'd0,
        STATUS_MISMATCH         = 3'd1,
        STATUS_UNSUPPORTED_HASH = 3'd2,
        STATUS_BAD_SIZES        = 3'd3,
        STATUS_LENGTH_WRONG     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        HASH_SHA256,
        HASH_SHA384,
        HASH_SHA512,
        HASH_NONE
    } hash_t;

    typedef enum logic {
        REQ_DIGEST  = 1'b0,
        REQ_MESSAGE = 1'b1
    } req_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic       valid_res;
        logic [2:0] status;
    } out_item_t;

    typedef struct packed {
        logic [MLEN_W-1:0] modulus_len;
        logic [MLEN_W-1:0] sep;
        hash_t             hash;
        logic              size_error;
        logic              usable;
    } cfg_t;

    typedef struct packed {
        logic       last;
        logic       compare;
        logic       use_ram;
        logic [7:0] exp_byte;
        logic [7:0] data_byte;
        status_t    pre_status;
    } stage_t;

    function automatic logic [7:0] prefix_byte(hash_t h, logic [PIDX_W-1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        unique case (idx)
            5'd0:  b = 8'h30;
            5'd1:  b = (h == HASH_SHA512) ? 8'h51 : (h == HASH_SHA384) ? 8'h41 : 8'h31;
            5'd2:  b = 8'h30;
            5'd3:  b = 8'h0d;
            5'd4:  b = 8'h06;
            5'd5:  b = 8'h09;
            5'd6:  b = 8'h60;
            5'd7:  b = 8'h86;
            5'd8:  b = 8'h48;
            5'd9:  b = 8'h01;
            5'd10: b = 8'h65;
            5'd11: b = 8'h03;
            5'd12: b = 8'h04;
            5'd13: b = 8'h02;
            5'd14: b = (h == HASH_SHA512) ? 8'h03 : (h == HASH_SHA384) ? 8'h02 : 8'h01;
            5'd15: b = 8'h05;
            5'd16: b = 8'h00;
            5'd17: b = 8'h04;
            5'd18: b = (h == HASH_SHA512) ? 8'h40 : (h == HASH_SHA384) ? 8'h30 : 8'h20;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== sv/pkcs1_cfg.sv =====
// ----------------------------------------------------------------------------
// pkcs1_cfg
// Configuration registers, the size and hash checks derived from them, and
// the separator position.
// ----------------------------------------------------------------------------
module pkcs1_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [pkcs1_pkg::CIDX_W-1:0] cfg_index,
    input  logic [pkcs1_pkg::CFG_W-1:0]  cfg_data,
    output pkcs1_pkg::cfg_t             cfg
);
    import pkcs1_pkg::*;

    logic [MLEN_W-1:0] modulus_len_reg;
    logic [DLEN_W-1:0] digest_len_reg;
    logic [MLEN_W-1:0] signature_len_reg;
    logic [MLEN_W:0]   min_len;
    hash_t             hash;
    logic              size_error;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_len_reg   <= MODULUS_LEN_RST;
            digest_len_reg    <= DIGEST_LEN_RST;
            signature_len_reg <= SIGNATURE_LEN_RST;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == REG_MODULUS_LEN)
                modulus_len_reg <= cfg_data;
            else if (cfg_index == REG_DIGEST_LEN)
                digest_len_reg <= cfg_data[DLEN_W-1:0];
            else if (cfg_index == REG_SIGNATURE_LEN)
                signature_len_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (digest_len_reg == 7'd32)
            hash = HASH_SHA256;
        else if (digest_len_reg == 7'd48)
            hash = HASH_SHA384;
        else if (digest_len_reg == 7'd64)
            hash = HASH_SHA512;
        else
            hash = HASH_NONE;

        min_len    = (MLEN_W+1)'(HEADER_BYTES) + {4'd0, digest_len_reg};
        size_error = ({1'b0, modulus_len_reg} > (MLEN_W+1)'(MAX_MODULUS_BYTES))
                  || ({1'b0, modulus_len_reg} < min_len)
                  || (signature_len_reg != modulus_len_reg);

        cfg.modulus_len = modulus_len_reg;
        cfg.sep         = modulus_len_reg - {3'd0, digest_len_reg}
                        - MLEN_W'(PREFIX_BYTES + 1);
        cfg.hash        = hash;
        cfg.size_error  = size_error;
        cfg.usable      = (hash != HASH_NONE) && !size_error;
    end

endmodule

// ===== sv/pkcs1_digest_ram.sv =====
// ----------------------------------------------------------------------------
// pkcs1_digest_ram
// Digest byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pkcs1_digest_ram (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [pkcs1_pkg::DADDR_W-1:0] wr_addr,
    input  logic [7:0]                   wr_data,
    input  logic                         rd_en,
    input  logic [pkcs1_pkg::DADDR_W-1:0] rd_addr,
    output logic [7:0]                   rd_data
);
    import pkcs1_pkg::*;

    logic [7:0] mem [MAX_DIGEST_BYTES];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/pkcs1_front.sv =====
// ----------------------------------------------------------------------------
// pkcs1_front
// Accept stage: digest loading, message position tracking, expected byte
// selection and early status.
// ----------------------------------------------------------------------------
module pkcs1_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pkcs1_pkg::cfg_t               cfg,
    input  logic                          accept,
    input  pkcs1_pkg::in_item_t           item,
    output logic                          ram_wr_en,
    output logic [pkcs1_pkg::DADDR_W-1:0] ram_wr_addr,
    output logic                          ram_rd_en,
    output logic [pkcs1_pkg::DADDR_W-1:0] ram_rd_addr,
    output logic                          stage_load,
    output pkcs1_pkg::stage_t             stage
);
    import pkcs1_pkg::*;

    logic [DLEN_W-1:0] digest_count_reg, digest_count_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              overrun_reg, overrun_next;
    logic              is_msg, beyond, overrun_now;
    logic [MLEN_W:0]   diff, ram_off;

    assign is_msg      = (item.req_type == REQ_MESSAGE);
    assign beyond      = (pos_reg >= cfg.modulus_len);
    assign overrun_now = overrun_reg || beyond;
    assign diff        = {1'b0, pos_reg} - {1'b0, cfg.sep};
    assign ram_off     = diff - (MLEN_W+1)'(PREFIX_BYTES + 1);

    assign ram_wr_en   = accept && !is_msg && (digest_count_reg < DLEN_W'(MAX_DIGEST_BYTES));
    assign ram_wr_addr = digest_count_reg[DADDR_W-1:0];
    assign ram_rd_en   = accept && is_msg;
    assign ram_rd_addr = ram_off[DADDR_W-1:0];
    assign stage_load  = accept && is_msg;

    always_comb
    begin
        stage.last      = item.last;
        stage.data_byte = item.data_byte;
        stage.compare   = cfg.usable && !beyond;
        stage.use_ram   = 1'b0;
        stage.exp_byte  = 8'hff;
        priority if (pos_reg == '0)
            stage.exp_byte = 8'h00;
        else if (pos_reg == POS_W'(1))
            stage.exp_byte = 8'h01;
        else if (diff[MLEN_W])
            stage.exp_byte = 8'hff;
        else if (diff == '0)
            stage.exp_byte = 8'h00;
        else if (diff <= (MLEN_W+1)'(PREFIX_BYTES))
            stage.exp_byte = prefix_byte(cfg.hash, PIDX_W'(diff - (MLEN_W+1)'(1)));
        else
            stage.use_ram = 1'b1;

        priority if (cfg.hash == HASH_NONE)
            stage.pre_status = STATUS_UNSUPPORTED_HASH;
        else if (cfg.size_error)
            stage.pre_status = STATUS_BAD_SIZES;
        else if (overrun_now
                 || (({1'b0, pos_reg} + (POS_W+1)'(1)) != {1'b0, cfg.modulus_len}))
            stage.pre_status = STATUS_LENGTH_WRONG;
        else
            stage.pre_status = STATUS_MATCH;
    end

    always_comb
    begin
        digest_count_next = digest_count_reg;
        pos_next          = pos_reg;
        overrun_next      = overrun_reg;
        if (accept && !is_msg)
        begin
            if (item.last)
                digest_count_next = '0;
            else if (ram_wr_en)
                digest_count_next = digest_count_reg + DLEN_W'(1);
        end
        if (accept && is_msg)
        begin
            if (item.last)
            begin
                pos_next     = '0;
                overrun_next = 1'b0;
            end
            else
            begin
                overrun_next = overrun_now;
                if (pos_reg != '1)
                    pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digest_count_reg <= '0;
            pos_reg          <= '0;
            overrun_reg      <= 1'b0;
        end
        else
        begin
            digest_count_reg <= digest_count_next;
            pos_reg          <= pos_next;
            overrun_reg      <= overrun_next;
        end
    end

endmodule

// ===== sv/pkcs1_verdict.sv =====
// ----------------------------------------------------------------------------
// pkcs1_verdict
// Compare stage against constant or stored digest byte, mismatch
// accumulation, and the result register.
// ----------------------------------------------------------------------------
module pkcs1_verdict (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 stage_load,
    input  pkcs1_pkg::stage_t    stage_in,
    input  logic [7:0]           ram_data,
    output logic                 stage_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pkcs1_pkg::out_item_t out_data
);
    import pkcs1_pkg::*;

    logic      s1_valid_reg, s1_valid_next;
    stage_t    s1_reg;
    logic      diff_reg, diff_next;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_reg, out_next;
    logic      advance, diff_now;
    logic [7:0] exp;
    status_t   status;

    assign stage_ready = !s1_valid_reg || !s1_reg.last || !out_valid_reg || out_ready;
    assign advance     = s1_valid_reg && stage_ready;
    assign exp         = s1_reg.use_ram ? ram_data : s1_reg.exp_byte;
    assign diff_now    = s1_reg.compare && (s1_reg.data_byte != exp);

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        diff_next      = diff_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        status         = s1_reg.pre_status;
        if (status == STATUS_MATCH && (diff_reg || diff_now))
            status = STATUS_MISMATCH;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (stage_ready)
            s1_valid_next = stage_load;
        if (advance)
        begin
            if (s1_reg.last)
            begin
                diff_next          = 1'b0;
                out_valid_next     = 1'b1;
                out_next.valid_res = (status == STATUS_MATCH);
                out_next.status    = status;
            end
            else
                diff_next = diff_reg || diff_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            diff_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            diff_reg      <= diff_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready && stage_load)
            s1_reg <= stage_in;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== sv/pkcs1_v15_encoding_check.sv =====
// ----------------------------------------------------------------------------
// pkcs1_v15_encoding_check
// PKCS#1 v1.5 signature encoding check: digest bytes load a store, message
// bytes are compared with 00 01 FF..FF 00 || DigestInfo || digest.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_data   (in_item_t)
//   out      output     out_valid / out_ready  out_data  (out_item_t)
//   cfg      input      cfg_wr_en              cfg_index, cfg_data
//
// One item per cycle while in_ready is high. A message byte is staged and its
// digest entry read when it is accepted; the staged byte is then compared, and
// on a last byte the verdict loads the result register as the stage advances.
// Reset leaves the digest store undefined; it must be loaded before use.
// in_ready drops only while a verdict is held behind a full, stalled result.
// ----------------------------------------------------------------------------
module pkcs1_v15_encoding_check (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  pkcs1_pkg::in_item_t          in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output pkcs1_pkg::out_item_t         out_data,
    input  logic                         cfg_wr_en,
    input  logic [pkcs1_pkg::CIDX_W-1:0] cfg_index,
    input  logic [pkcs1_pkg::CFG_W-1:0]  cfg_data
);
    import pkcs1_pkg::*;

    cfg_t                cfg;
    stage_t              stage;
    logic                accept, stage_load, stage_ready;
    logic                ram_wr_en, ram_rd_en;
    logic [DADDR_W-1:0]  ram_wr_addr, ram_rd_addr;
    logic [7:0]          ram_data;

    assign in_ready = stage_ready;
    assign accept   = in_valid && stage_ready;

    pkcs1_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pkcs1_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .accept      (accept),
        .item        (in_data),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .stage_load  (stage_load),
        .stage       (stage)
    );

    pkcs1_digest_ram u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (in_data.data_byte),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_data)
    );

    pkcs1_verdict u_verdict (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_load  (stage_load),
        .stage_in    (stage),
        .ram_data    (ram_data),
        .stage_ready (stage_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: PKCS#1 v1.5 signature encoding check
// Loads the digest store, then streams recovered message bytes: well-formed
// encodings for each hash, single-byte corruptions, unsupported hash lengths,
// bad size settings, short, long and overlong streams, and digest loads
// mixed into a message. A predictor tracks the block's state and queues one
// verdict per message. Results are checked in order. Both sides idle and
// stall at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pkcs1_pkg::*;

    localparam int unsigned RANDOM_ITEMS  = 100;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES   = 80;

    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_RARE} rx_mode_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    in_item_t            in_data;
    logic                out_valid;
    logic                out_ready;
    out_item_t           out_data;
    logic                cfg_wr_en;
    logic [CIDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]    cfg_data;

    // predictor state
    logic [MLEN_W-1:0]   cfg_modulus   = MODULUS_LEN_RST;
    logic [DLEN_W-1:0]   cfg_digest    = DIGEST_LEN_RST;
    logic [MLEN_W-1:0]   cfg_signature = SIGNATURE_LEN_RST;
    logic [7:0]          dig_mem [MAX_DIGEST_BYTES];
    int unsigned         dig_fill    = 0;
    int unsigned         msg_pos     = 0;
    bit                  msg_differs = 1'b0;
    bit                  msg_overrun = 1'b0;
    out_item_t           verdicts_due [$];

    int unsigned         fail_count = 0;
    int unsigned         items_sent = 0;
    int unsigned         burst_left = 0;
    bit                  hold_off   = 1'b0;

    pkcs1_v15_encoding_check u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit hash_known();
        return cfg_digest == 7'd32 || cfg_digest == 7'd48 || cfg_digest == 7'd64;
    endfunction

    function automatic bit size_error();
        return cfg_modulus > MAX_MODULUS_BYTES || cfg_modulus < HEADER_BYTES + cfg_digest
            || cfg_signature != cfg_modulus;
    endfunction

    function automatic bit layout_usable();
        return hash_known() && !size_error();
    endfunction

    function automatic logic [7:0] digest_info_byte(input int idx);
        logic [7:0] b;
        b = 8'h00;
        case (idx)
            0:  b = 8'h30;
            1:  b = (cfg_digest == 7'd64) ? 8'h51 : (cfg_digest == 7'd48) ? 8'h41 : 8'h31;
            2:  b = 8'h30;
            3:  b = 8'h0d;
            4:  b = 8'h06;
            5:  b = 8'h09;
            6:  b = 8'h60;
            7:  b = 8'h86;
            8:  b = 8'h48;
            9:  b = 8'h01;
            10: b = 8'h65;
            11: b = 8'h03;
            12: b = 8'h04;
            13: b = 8'h02;
            14: b = (cfg_digest == 7'd64) ? 8'h03 : (cfg_digest == 7'd48) ? 8'h02 : 8'h01;
            15: b = 8'h05;
            16: b = 8'h00;
            17: b = 8'h04;
            18: b = (cfg_digest == 7'd64) ? 8'h40 : (cfg_digest == 7'd48) ? 8'h30 : 8'h20;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // 00 01 FF..FF 00 || DigestInfo || digest, valid only for a usable layout
    function automatic logic [7:0] expected_byte(input int pos);
        int sep;
        sep = int'(cfg_modulus) - int'(cfg_digest) - PREFIX_BYTES - 1;
        if (pos == 0)
            return 8'h00;
        if (pos == 1)
            return 8'h01;
        if (pos < sep)
            return 8'hff;
        if (pos == sep)
            return 8'h00;
        if (pos <= sep + PREFIX_BYTES)
            return digest_info_byte(pos - sep - 1);
        return dig_mem[(pos - sep - 1 - PREFIX_BYTES) % MAX_DIGEST_BYTES];
    endfunction

    task automatic predict_verdict(input in_item_t item);
        out_item_t v;
        status_t   st;
        if (item.req_type == REQ_DIGEST)
        begin
            if (dig_fill < MAX_DIGEST_BYTES)
            begin
                dig_mem[dig_fill] = item.data_byte;
                dig_fill++;
            end
            if (item.last)
                dig_fill = 0;
            return;
        end
        if (msg_pos >= cfg_modulus)
            msg_overrun = 1'b1;
        else if (layout_usable() && item.data_byte != expected_byte(msg_pos))
            msg_differs = 1'b1;
        if (!item.last)
        begin
            if (msg_pos < 1023)
                msg_pos++;
            return;
        end
        if (!hash_known())
            st = STATUS_UNSUPPORTED_HASH;
        else if (size_error())
            st = STATUS_BAD_SIZES;
        else if (msg_overrun || msg_pos + 1 != cfg_modulus)
            st = STATUS_LENGTH_WRONG;
        else if (msg_differs)
            st = STATUS_MISMATCH;
        else
            st = STATUS_MATCH;
        v.valid_res = (st == STATUS_MATCH);
        v.status    = st;
        verdicts_due.push_back(v);
        msg_pos     = 0;
        msg_differs = 1'b0;
        msg_overrun = 1'b0;
    endtask

    task automatic report_error(input string msg);
        $display("ERROR %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (verdicts_due.size() == 0)
                report_error($sformatf("verdict %0d/%0d with none pending",
                                       out_data.valid_res, out_data.status));
            else
            begin
                want = verdicts_due.pop_front();
                if (out_data.valid_res !== want.valid_res)
                    report_error($sformatf("valid_res %0b, want %0b",
                                           out_data.valid_res, want.valid_res));
                if (out_data.status !== want.status)
                    report_error($sformatf("status %0d, want %0d",
                                           out_data.status, want.status));
            end
        end
    end

    // receiver: random stall modes, plus a long hold-off on request
    initial
    begin
        rx_mode_t    mode;
        int unsigned span;
        int unsigned phase;
        out_ready = 1'b0;
        mode  = RX_ALWAYS;
        span  = 0;
        phase = 0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off = 1'b0;
            end
            else
            begin
                if (span == 0)
                begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    span = $urandom_range(20, 300);
                end
                span--;
                phase++;
                case (mode)
                    RX_ALWAYS:  out_ready <= 1'b1;
                    RX_RANDOM:  out_ready <= 1'($urandom_range(0, 1));
                    RX_PATTERN: out_ready <= (phase % 5) < 3;
                    default:    out_ready <= $urandom_range(0, 15) != 0;
                endcase
            end
        end
    end

    task automatic send_item(input in_item_t item);
        int unsigned gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 300)
                                                     : $urandom_range(1, 24);
            gap = $urandom_range(0, 5);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        burst_left--;
        items_sent++;
        predict_verdict(item);
    endtask

    task automatic wait_results_done();
        @(negedge clk);
        in_valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_MODULUS_LEN:   cfg_modulus   = val;
            REG_DIGEST_LEN:    cfg_digest    = val[DLEN_W-1:0];
            REG_SIGNATURE_LEN: cfg_signature = val;
            default: ;
        endcase
    endtask

    task automatic set_sizes(input int modulus, input int digest, input int signature);
        wait_results_done();
        write_reg(REG_MODULUS_LEN, CFG_W'(modulus));
        write_reg(REG_DIGEST_LEN, CFG_W'(digest));
        write_reg(REG_SIGNATURE_LEN, CFG_W'(signature));
        repeat (4) @(negedge clk);
    endtask

    task automatic load_digest(input int count, input bit with_last);
        in_item_t item;
        for (int i = 0; i < count; i++)
        begin
            item.req_type  = REQ_DIGEST;
            item.data_byte = 8'($urandom_range(0, 255));
            item.last      = with_last && (i == count - 1);
            send_item(item);
        end
    endtask

    // bytes follow the expected encoding unless noise; flip_at corrupts one
    task automatic send_message(input int len, input int flip_at, input bit noise,
                                input int unsigned dig_pct);
        in_item_t item;
        for (int p = 0; p < len; p++)
        begin
            if (dig_pct != 0 && $urandom_range(0, 99) < dig_pct)
                load_digest(1, $urandom_range(0, 7) == 0);
            item.req_type = REQ_MESSAGE;
            if (noise || !layout_usable() || msg_pos >= cfg_modulus)
                item.data_byte = 8'($urandom_range(0, 255));
            else
                item.data_byte = expected_byte(msg_pos);
            if (p == flip_at)
                item.data_byte ^= 8'($urandom_range(1, 255));
            item.last = (p == len - 1);
            send_item(item);
        end
    endtask

    function automatic int message_len();
        if (layout_usable())
            return cfg_modulus;
        if (cfg_modulus >= 1 && cfg_modulus <= 140)
            return cfg_modulus;
        return $urandom_range(1, 140);
    endfunction

    task automatic test_digest_store();
        load_digest(MAX_DIGEST_BYTES, 1'b1);
        send_message(cfg_modulus, -1, 1'b0, 0);
        // bytes past the store size are dropped
        load_digest(MAX_DIGEST_BYTES + 6, 1'b1);
        set_sizes(HEADER_BYTES + 64, 64, HEADER_BYTES + 64);
        send_message(cfg_modulus, -1, 1'b0, 0);
    endtask

    task automatic test_hash_lengths();
        set_sizes(HEADER_BYTES + 32, 32, HEADER_BYTES + 32);
        send_message(cfg_modulus, -1, 1'b0, 0);
        set_sizes(HEADER_BYTES + 48, 48, HEADER_BYTES + 48);
        send_message(cfg_modulus, -1, 1'b0, 0);
        set_sizes(MAX_MODULUS_BYTES, 64, MAX_MODULUS_BYTES);
        send_message(4, -1, 1'b0, 0);
        set_sizes(HEADER_BYTES + 32, 10'h3a0, HEADER_BYTES + 32);
        send_message(3, -1, 1'b0, 0);
    endtask

    task automatic test_mismatch();
        int sep;
        set_sizes(HEADER_BYTES + 32, 32, HEADER_BYTES + 32);
        sep = int'(cfg_modulus) - 32 - PREFIX_BYTES - 1;
        send_message(cfg_modulus, 1, 1'b0, 0);
        send_message(cfg_modulus, sep, 1'b0, 0);
        send_message(cfg_modulus, sep + 1, 1'b0, 0);
        send_message(cfg_modulus, sep + PREFIX_BYTES + 1, 1'b0, 0);
        send_message(cfg_modulus, cfg_modulus - 1, 1'b0, 0);
    endtask

    task automatic test_unsupported_hash();
        set_sizes(80, 0, 80);
        send_message(8, -1, 1'b0, 0);
        set_sizes(80, 31, 80);
        send_message(8, -1, 1'b0, 0);
        set_sizes(80, 33, 80);
        send_message(3, -1, 1'b0, 0);
        set_sizes(80, 10'h3ff, 80);
        send_message(8, -1, 1'b0, 0);
        // unsupported hash outranks bad sizes
        set_sizes(0, 0, 5);
        send_message(5, -1, 1'b0, 0);
    endtask

    task automatic test_bad_sizes();
        set_sizes(MAX_MODULUS_BYTES + 1, 32, MAX_MODULUS_BYTES + 1);
        send_message(6, -1, 1'b0, 0);
        set_sizes(1023, 64, 1023);
        send_message(6, -1, 1'b0, 0);
        set_sizes(HEADER_BYTES + 47, 48, HEADER_BYTES + 47);
        send_message(6, -1, 1'b0, 0);
        set_sizes(HEADER_BYTES + 32, 32, HEADER_BYTES + 33);
        send_message(6, -1, 1'b0, 0);
        set_sizes(0, 32, 0);
        send_message(4, -1, 1'b0, 0);
        set_sizes(500, 64, MAX_MODULUS_BYTES);
        send_message(6, -1, 1'b0, 0);
    endtask

    task automatic test_stream_length();
        set_sizes(HEADER_BYTES + 32, 32, HEADER_BYTES + 32);
        send_message(cfg_modulus - 1, -1, 1'b0, 0);
        send_message(cfg_modulus + 1, -1, 1'b0, 0);
        send_message(1, -1, 1'b0, 0);
        send_message(cfg_modulus + 1, 5, 1'b0, 0);
        // bytes well past the end still flag the length
        send_message(cfg_modulus + 20, -1, 1'b0, 0);
    endtask

    task automatic test_digest_mid_message();
        set_sizes(HEADER_BYTES + 32, 32, HEADER_BYTES + 32);
        send_message(cfg_modulus, -1, 1'b0, 25);
        load_digest(MAX_DIGEST_BYTES + 6, 1'b0);
        send_message(cfg_modulus, -1, 1'b0, 25);
        load_digest(1, 1'b1);
        send_message(cfg_modulus, -1, 1'b0, 0);
    endtask

    task automatic test_backpressure();
        set_sizes(HEADER_BYTES + 32, 32, HEADER_BYTES + 32);
        hold_off   = 1'b1;
        burst_left = 200;
        repeat (16) send_message(1, -1, 1'b1, 0);
        send_message(cfg_modulus, -1, 1'b0, 0);
        wait_results_done();
    endtask

    task automatic random_message();
        int unsigned pick;
        int          len;
        pick = $urandom_range(0, 99);
        len  = message_len();
        if (pick < 55)
            send_message(len, -1, 1'b0, ($urandom_range(0, 3) == 0) ? 5 : 0);
        else if (pick < 70)
            send_message(len, $urandom_range(0, len - 1), 1'b0, 0);
        else if (pick < 82)
        begin
            if ($urandom_range(0, 1) == 0)
                len = len + $urandom_range(1, 4);
            else
                len = len - $urandom_range(1, 4);
            if (len < 1)
                len = 1;
            send_message(len, -1, 1'b0, 0);
        end
        else if (pick < 92)
            send_message($urandom_range(1, 80), -1, 1'b1, 3);
        else
            load_digest($urandom_range(1, 70), $urandom_range(0, 3) != 0);
    endtask

    task automatic test_random();
        int unsigned start;
        int unsigned pick;
        int          modulus;
        int          digest;
        int          signature;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            pick   = $urandom_range(0, 99);
            digest = 32 + 16 * $urandom_range(0, 2);
            if (pick < 70)
            begin
                modulus   = HEADER_BYTES + digest + $urandom_range(0, 30);
                signature = modulus;
            end
            else if (pick < 80)
            begin
                digest = $urandom_range(0, 1023);
                if ((digest & 7'h7f) == 32 || (digest & 7'h7f) == 48 || (digest & 7'h7f) == 64)
                    digest = digest ^ 1;
                modulus   = $urandom_range(62, 140);
                signature = modulus;
            end
            else if (pick < 90)
            begin
                case ($urandom_range(0, 2))
                    0: modulus = $urandom_range(0, HEADER_BYTES + digest - 1);
                    1: modulus = $urandom_range(MAX_MODULUS_BYTES + 1, 1023);
                    default: modulus = HEADER_BYTES + digest + $urandom_range(0, 30);
                endcase
                signature = modulus;
                if (modulus <= MAX_MODULUS_BYTES && modulus >= HEADER_BYTES + digest)
                    signature = modulus ^ (1 << $urandom_range(0, 9));
            end
            else
            begin
                modulus   = $urandom_range(0, 1023);
                digest    = $urandom_range(0, 1023);
                signature = ($urandom_range(0, 1) == 0) ? modulus : $urandom_range(0, 1023);
            end
            set_sizes(modulus, digest, signature);
            repeat ($urandom_range(1, 3)) random_message();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_MODULUS_LEN;
        cfg_data  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_digest_store();
        test_hash_lengths();
        test_mismatch();
        test_unsupported_hash();
        test_bad_sizes();
        test_stream_length();
        test_digest_mid_message();
        test_backpressure();
        test_random();

        wait_results_done();
        if (fail_count == 0)
            $display("PASS pkcs1_v15_encoding_check");
        else
            $display("FAIL pkcs1_v15_encoding_check");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("FAIL pkcs1_v15_encoding_check");
        $finish;
    end

endmodule

// ===== files.f =====
sv/pkcs1_pkg.sv
sv/pkcs1_cfg.sv
sv/pkcs1_digest_ram.sv
sv/pkcs1_front.sv
sv/pkcs1_verdict.sv
sv/pkcs1_v15_encoding_check.sv
tb/tb.sv
